@@ src/pwm_timer_setting_calculator_top_defines.svh @@
// Assertion macros for the PWM timer setting calculator checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef PWM_TIMER_SETTING_CALCULATOR_TOP_DEFINES_SVH
`define PWM_TIMER_SETTING_CALCULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTSC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/ptsc_pkg.sv @@
// Shared types and constants of the PWM timer setting calculator.
// No dependencies; every other file but the assertion macro header imports this package.
`default_nettype none

package ptsc_pkg;

  localparam int unsigned CHANNELS_DEF = 2;
  localparam int unsigned FIFO_DEPTH   = 2;

  localparam logic [31:0] CLK_HZ_RESET = 32'd240000000;
  localparam logic [9:0]  DUTY_FULL    = 10'd1000;
  localparam logic [31:0] DUTY_DIVISOR = 32'd1000;
  localparam logic [31:0] TICKS_MIN    = 32'd2;
  localparam logic [31:0] RELOAD_MIN   = 32'd2;
  localparam logic [31:0] RELOAD_LIMIT = 32'h0001_0000;

  // Reciprocal of 1000 scaled by 2^36, exact for any reload times a duty up to full scale.
  localparam logic [26:0] DUTY_RECIP   = 27'd68719477;

  localparam logic [1:0] MODE_CONFIG = 2'd0;
  localparam logic [1:0] MODE_DUTY   = 2'd1;
  localparam logic [1:0] MODE_ENABLE = 2'd2;

  typedef enum logic [2:0] {
    K_CONFIG,
    K_DUTY,
    K_ENABLE,
    K_REJECT,
    K_BAD_CH
  } kind_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  channel;
    logic [31:0] frequency_hz;
    logic [9:0]  duty_permille;
    logic        enable_flag;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [15:0] compare;
    logic        output_enable;
    logic        counter_run;
  } result_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  channel;
    logic [31:0] freq;
    logic [9:0]  duty;
    logic        flag;
  } cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  localparam result_t RES_BAD_CH = '{status: 1'b1, default: '0};

endpackage

`default_nettype wire

@@ src/ptsc_fifo.sv @@
// Small two-sided queue used for commands and for results.
// Depends on ptsc_pkg for its depth.
`default_nettype none

module ptsc_fifo
  import ptsc_pkg::*;
#(
  parameter type T = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  T                mem_q [FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ptsc_front.sv @@
// Request classifier: sorts each request into a command kind and saturates the duty of configure requests.
// Depends on ptsc_pkg.
`default_nettype none

module ptsc_front
  import ptsc_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire req_t req_i,
  output cmd_t      cmd_o
);

  always_comb begin
    cmd_o.channel = req_i.channel;
    cmd_o.freq    = req_i.frequency_hz;
    cmd_o.duty    = req_i.duty_permille;
    cmd_o.flag    = req_i.enable_flag;
    cmd_o.kind    = K_REJECT;
    if ({24'd0, req_i.channel} >= 32'(CHANNELS)) begin
      cmd_o.kind = K_BAD_CH;
    end else begin
      case (req_i.mode)
        MODE_CONFIG: begin
          if (req_i.frequency_hz != '0) begin
            cmd_o.kind = K_CONFIG;
          end
          if (req_i.duty_permille > DUTY_FULL) begin
            cmd_o.duty = DUTY_FULL;
          end
        end
        MODE_DUTY: begin
          if (req_i.duty_permille <= DUTY_FULL) begin
            cmd_o.kind = K_DUTY;
          end
        end
        MODE_ENABLE: begin
          cmd_o.kind = K_ENABLE;
        end
        default: begin
          cmd_o.kind = K_REJECT;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/ptsc_div.sv @@
// Radix-2 restoring divider, 32 by 32 bits, one quotient bit per cycle.
// Depends on ptsc_pkg for its request and response types.
`default_nettype none

module ptsc_div
  import ptsc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q;
  logic [31:0] quo_q;
  logic [31:0] dvs_q;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        fits;

  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
      end else if (busy_q) begin
        rem_q <= fits ? diff[31:0] : shifted[31:0];
        quo_q <= {quo_q[30:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ src/ptsc_back.sv @@
// Command executor: channel state, timer clock register and the sequencer
// that drives the shared divider. Depends on ptsc_pkg and ptsc_div.
`default_nettype none

module ptsc_back
  import ptsc_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_empty_i,
  output logic             cmd_pop_o,
  input  wire logic        res_full_i,
  output logic             res_push_o,
  output result_t          res_o,
  input  wire logic        cfg_valid_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_TICKS,
    ST_DIV_RELOAD,
    ST_MUL,
    ST_SCALE
  } state_e;

  state_e      state_q;
  cmd_t        cmd_q;
  logic        cmd_pop_q;
  logic        res_push_q;
  result_t     res_q;
  div_req_t    div_q;
  div_rsp_t    div_rsp;
  logic [31:0] clk_hz_q;

  logic [15:0] psc_q  [CHANNELS];
  logic [15:0] rel_q  [CHANNELS];
  logic [9:0]  duty_q [CHANNELS];
  logic [15:0] cmp_q  [CHANNELS];
  logic        cfg_q  [CHANNELS];
  logic        en_q   [CHANNELS];
  logic        run_q  [CHANNELS];

  logic [15:0] st_psc_q;
  logic [15:0] st_rel_q;
  logic [9:0]  st_duty_q;
  logic        st_en_q;
  logic        st_run_q;
  logic [25:0] prod_q;

  logic [ChW-1:0] ci;
  result_t        cur_res;
  logic [16:0]    ticks_ceil;
  logic [25:0]    prod;
  logic [52:0]    cmp_prod;
  logic [15:0]    cmp_new;

  ptsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_q),
    .rsp_o  (div_rsp)
  );

  assign ci         = cmd_q.channel[ChW-1:0];
  assign ticks_ceil = {1'b0, div_rsp.quot[31:16]} + {16'd0, |div_rsp.quot[15:0]};
  assign prod       = {10'd0, st_rel_q} * {16'd0, st_duty_q};
  assign cmp_prod   = {27'd0, prod_q} * {26'd0, DUTY_RECIP};
  assign cmp_new    = st_en_q ? cmp_prod[51:36] : 16'd0;

  always_comb begin
    cur_res.status        = 1'b1;
    cur_res.prescaler     = psc_q[ci];
    cur_res.reload        = rel_q[ci];
    cur_res.compare       = cmp_q[ci];
    cur_res.output_enable = en_q[ci];
    cur_res.counter_run   = run_q[ci];
  end

  assign cmd_pop_o  = cmd_pop_q;
  assign res_push_o = res_push_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cmd_q      <= '0;
      cmd_pop_q  <= 1'b0;
      res_push_q <= 1'b0;
      res_q      <= '0;
      div_q      <= '0;
      clk_hz_q   <= CLK_HZ_RESET;
      st_psc_q   <= '0;
      st_rel_q   <= '0;
      st_duty_q  <= '0;
      st_en_q    <= 1'b0;
      st_run_q   <= 1'b0;
      prod_q     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        psc_q[i]  <= '0;
        rel_q[i]  <= '0;
        duty_q[i] <= '0;
        cmp_q[i]  <= '0;
        cfg_q[i]  <= 1'b0;
        en_q[i]   <= 1'b0;
        run_q[i]  <= 1'b0;
      end
    end else begin
      div_q.start <= 1'b0;
      cmd_pop_q   <= 1'b0;
      res_push_q  <= 1'b0;
      if (cfg_valid_i) begin
        clk_hz_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i && !res_full_i && !res_push_q) begin
            cmd_q     <= cmd_i;
            cmd_pop_q <= 1'b1;
            state_q   <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          case (cmd_q.kind)
            K_BAD_CH: begin
              res_q      <= RES_BAD_CH;
              res_push_q <= 1'b1;
              state_q    <= ST_IDLE;
            end
            K_CONFIG: begin
              st_duty_q      <= cmd_q.duty;
              st_en_q        <= en_q[ci];
              st_run_q       <= 1'b0;
              div_q.start    <= 1'b1;
              div_q.dividend <= clk_hz_q;
              div_q.divisor  <= cmd_q.freq;
              state_q        <= ST_DIV_TICKS;
            end
            K_DUTY, K_ENABLE: begin
              if (!cfg_q[ci]) begin
                res_q      <= cur_res;
                res_push_q <= 1'b1;
                state_q    <= ST_IDLE;
              end else begin
                st_psc_q <= psc_q[ci];
                st_rel_q <= rel_q[ci];
                if (cmd_q.kind == K_DUTY) begin
                  st_duty_q <= cmd_q.duty;
                  st_en_q   <= en_q[ci];
                  st_run_q  <= run_q[ci];
                end else begin
                  st_duty_q <= duty_q[ci];
                  st_en_q   <= cmd_q.flag;
                  st_run_q  <= run_q[ci] | cmd_q.flag;
                end
                state_q <= ST_MUL;
              end
            end
            default: begin
              res_q      <= cur_res;
              res_push_q <= 1'b1;
              state_q    <= ST_IDLE;
            end
          endcase
        end
        ST_DIV_TICKS: begin
          if (div_rsp.done) begin
            if (div_rsp.quot < TICKS_MIN) begin
              res_q      <= cur_res;
              res_push_q <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              st_psc_q       <= ticks_ceil[15:0] - 16'd1;
              div_q.start    <= 1'b1;
              div_q.dividend <= div_rsp.quot;
              div_q.divisor  <= {15'd0, ticks_ceil};
              state_q        <= ST_DIV_RELOAD;
            end
          end
        end
        ST_DIV_RELOAD: begin
          if (div_rsp.done) begin
            if ((div_rsp.quot < RELOAD_MIN) || (div_rsp.quot > RELOAD_LIMIT)) begin
              res_q      <= cur_res;
              res_push_q <= 1'b1;
              state_q    <= ST_IDLE;
            end else begin
              st_rel_q <= div_rsp.quot[15:0] - 16'd1;
              state_q  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          prod_q  <= prod;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          psc_q[ci]             <= st_psc_q;
          rel_q[ci]             <= st_rel_q;
          duty_q[ci]            <= st_duty_q;
          cmp_q[ci]             <= cmp_new;
          cfg_q[ci]             <= 1'b1;
          en_q[ci]              <= st_en_q;
          run_q[ci]             <= st_run_q;
          res_q.status          <= 1'b0;
          res_q.prescaler       <= st_psc_q;
          res_q.reload          <= st_rel_q;
          res_q.compare         <= cmp_new;
          res_q.output_enable   <= st_en_q;
          res_q.counter_run     <= st_run_q;
          res_push_q            <= 1'b1;
          state_q               <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pwm_timer_setting_calculator_top.sv @@
// Top level of the PWM timer setting calculator.
// Depends on ptsc_pkg, ptsc_front, ptsc_fifo and ptsc_back.
//
// Each request configures a channel's frequency, sets its duty, or enables or
// disables it, and yields one result with a status and the channel's settings.
// Requests are handled one at a time by a sequencer that shares a single
// 32-bit divider retiring one quotient bit per cycle. A configure runs two
// divisions (ticks, reload) and then scales the compare value; a duty or
// enable request scales the compare value with a reciprocal multiplication;
// a request that is rejected before any division is answered from the
// decode step. Two-entry queues sit on the request and result sides, so
// up to two requests may be pushed and two results may wait while the
// sequencer works. The timer clock register may be written in any cycle and
// always accepts a transfer, but should only change while no request is
// pending.
`default_nettype none

module pwm_timer_setting_calculator_top
  import ptsc_pkg::*;
#(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire req_t        in_item_i,
  output logic             full,
  input  wire logic        pop,
  output result_t          out_item_o,
  output logic             empty,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_data_i
);

  cmd_t    front_cmd;
  cmd_t    back_cmd;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_full;
  logic    res_push;
  result_t back_res;

  assign cfg_ready_o = 1'b1;

  ptsc_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .req_i (in_item_i),
    .cmd_o (front_cmd)
  );

  ptsc_fifo #(
    .T (cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  ptsc_back #(
    .CHANNELS (CHANNELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i)
  );

  ptsc_fifo #(
    .T (result_t)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

@@ src/ptsc_checker.sv @@
// Port-level checks of the PWM timer setting calculator, bound to its top level.
// Depends on ptsc_pkg and pwm_timer_setting_calculator_top_defines.svh.
`default_nettype none

`include "pwm_timer_setting_calculator_top_defines.svh"

module ptsc_checker
  import ptsc_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pop,
  input wire result_t     out_item_o,
  input wire logic        empty
);

  // A compare value never exceeds the reload because the duty is capped at full scale.
  `PTSC_ASSERT_IMPL(a_cmp_le_reload, !empty, out_item_o.compare <= out_item_o.reload)

  // A disabled output always reports a zero compare value.
  `PTSC_ASSERT_IMPL(a_cmp_zero_off, !empty && !out_item_o.output_enable,
                    out_item_o.compare == 16'd0)

  // An accepted request always leaves a configured channel with a nonzero reload.
  `PTSC_ASSERT_IMPL(a_ok_has_reload, !empty && !out_item_o.status,
                    out_item_o.reload != 16'd0)

  // A waiting result that is not taken stays in place unchanged.
  `PTSC_ASSERT_NEXT(a_res_holds, !empty && !pop, !empty && $stable(out_item_o))

endmodule

bind pwm_timer_setting_calculator_top ptsc_checker u_checker (.*);

`default_nettype wire

@@ tb/tb_pwm_timer_setting_calculator_top.sv @@
// Self-checking testbench for the PWM timer setting calculator top level.
// Depends on ptsc_pkg and pwm_timer_setting_calculator_top; it predicts every
// result from its own channel model and checks each popped result against it.
`default_nettype none

module tb_pwm_timer_setting_calculator_top
  import ptsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_CH      = CHANNELS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned DRAIN_WAIT  = 200;
  localparam int unsigned NUM_PHASES  = 7;
  localparam logic [1:0]  MODE_UNKNOWN = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  req_t        in_item_i = '0;
  logic        full;
  logic        pop = 1'b0;
  result_t     out_item_o;
  logic        empty;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  pwm_timer_setting_calculator_top #(
    .CHANNELS(NUM_CH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .pop        (pop),
    .out_item_o (out_item_o),
    .empty      (empty),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // Channel model and timer clock as the block should hold them.
  logic [31:0] timer_hz = CLK_HZ_RESET;
  logic [15:0] ch_prescaler [NUM_CH];
  logic [15:0] ch_reload [NUM_CH];
  logic [15:0] ch_compare [NUM_CH];
  logic [9:0]  ch_duty [NUM_CH];
  logic        ch_configured [NUM_CH];
  logic        ch_enabled [NUM_CH];
  logic        ch_running [NUM_CH];

  req_t        request_backlog [$];
  result_t     pending_results [$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned granted_total = 0;
  int unsigned refused_total = 0;
  int unsigned fail_count = 0;
  int unsigned cycles = 0;
  logic        req_taken = 1'b0;
  logic        quiet = 1'b0;
  int unsigned send_gap = 0;
  int unsigned pop_gap = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic void refresh_compare(int unsigned c);
    logic [31:0] scaled;
    scaled = (32'(ch_reload[c]) * 32'(ch_duty[c])) / DUTY_DIVISOR;
    ch_compare[c] = ch_enabled[c] ? scaled[15:0] : 16'd0;
  endfunction

  function automatic result_t apply_request(req_t r);
    result_t     res;
    logic [63:0] ticks;
    logic [63:0] psc;
    logic [63:0] arr;
    logic        ok;
    int unsigned c;
    res = '0;
    ok = 1'b0;
    if (r.channel >= NUM_CH) begin
      res.status = 1'b1;
      return res;
    end
    c = 32'(r.channel);
    case (r.mode)
      MODE_CONFIG: begin
        if (r.frequency_hz != 32'd0) begin
          ticks = 64'(timer_hz) / 64'(r.frequency_hz);
          if (ticks >= 64'd2) begin
            psc = (ticks + 64'd65535) / 64'd65536 - 64'd1;
            arr = ticks / (psc + 64'd1);
            if (arr >= 64'd2 && arr - 64'd1 <= 64'hFFFF && psc <= 64'hFFFF) begin
              ch_prescaler[c] = psc[15:0];
              ch_reload[c] = 16'(arr - 64'd1);
              ch_duty[c] = (r.duty_permille > DUTY_FULL) ? DUTY_FULL : r.duty_permille;
              ch_configured[c] = 1'b1;
              ch_running[c] = 1'b0;
              refresh_compare(c);
              ok = 1'b1;
            end
          end
        end
      end
      MODE_DUTY: begin
        if (r.duty_permille <= DUTY_FULL && ch_configured[c]) begin
          ch_duty[c] = r.duty_permille;
          refresh_compare(c);
          ok = 1'b1;
        end
      end
      MODE_ENABLE: begin
        if (ch_configured[c]) begin
          ch_enabled[c] = r.enable_flag;
          refresh_compare(c);
          if (r.enable_flag) begin
            ch_running[c] = 1'b1;
          end
          ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.status = ~ok;
    res.prescaler = ch_prescaler[c];
    res.reload = ch_reload[c];
    res.compare = ch_compare[c];
    res.output_enable = ch_enabled[c];
    res.counter_run = ch_running[c];
    return res;
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] pick_frequency();
    logic [31:0] target;
    logic [31:0] freq;
    case ($urandom_range(0, 3))
      0: target = $urandom_range(2, 300);
      1: target = $urandom_range(300, 65536);
      2: target = $urandom_range(65537, 4_000_000);
      default: target = $urandom;
    endcase
    if (target == 32'd0) begin
      target = 32'd1;
    end
    freq = timer_hz / target;
    return (freq == 32'd0) ? 32'd1 : freq;
  endfunction

  task automatic queue_req(logic [1:0] mode, logic [7:0] ch, logic [31:0] freq,
                           logic [9:0] duty, logic flag);
    req_t r;
    r.mode = mode;
    r.channel = ch;
    r.frequency_hz = freq;
    r.duty_permille = duty;
    r.enable_flag = flag;
    request_backlog.push_back(r);
    queued_total++;
  endtask

  // Configure a channel, then work it with duty and enable requests.
  task automatic add_sequence();
    logic [7:0] ch;
    logic [9:0] duty;
    int unsigned n;
    ch = 8'($urandom_range(0, NUM_CH - 1));
    n = $urandom_range(1, 6);
    queue_req(MODE_CONFIG, ch, pick_frequency(), 10'($urandom_range(0, 1023)),
              1'($urandom));
    for (int i = 0; i < n; i++) begin
      duty = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(1001, 1023))
                                         : 10'($urandom_range(0, 1000));
      if ($urandom_range(0, 1) == 0) begin
        queue_req(MODE_DUTY, ch, $urandom, duty, 1'($urandom));
      end else begin
        queue_req(MODE_ENABLE, ch, $urandom, duty, 1'($urandom));
      end
    end
  endtask

  task automatic add_noise();
    logic [7:0]  ch;
    logic [31:0] freq;
    ch = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, NUM_CH - 1))
                                     : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: freq = $urandom;
      1: freq = 32'd0;
      default: freq = pick_frequency();
    endcase
    queue_req(2'($urandom_range(0, 3)), ch, freq, 10'($urandom_range(0, 1023)),
              1'($urandom));
  endtask

  task automatic drain();
    while (accepted_total != queued_total || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_timer_clock(logic [31:0] hz);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    timer_hz = hz;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Driver: presents queued requests and pops results, both with random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !req_taken) begin
      end else if (send_gap > 0) begin
        push = 1'b0;
        send_gap--;
      end else if (request_backlog.size() > 0) begin
        in_item_i = request_backlog.pop_front();
        push = 1'b1;
        send_gap = draw_gap();
      end else begin
        push = 1'b0;
      end
      if (pop_gap > 0) begin
        pop = 1'b0;
        pop_gap--;
      end else begin
        pop = 1'b1;
        pop_gap = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
      end
    end
  end

  // Monitor: predicts each accepted request and checks each popped result.
  always @(posedge clk_i) begin
    result_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("pwm_timer_setting_calculator_top verification failed");
      $finish;
    end else begin
      req_taken = rst_ni && push && !full;
      if (req_taken) begin
        want = apply_request(in_item_i);
        pending_results.push_back(want);
        accepted_total++;
        if (want.status) begin
          refused_total++;
        end else begin
          granted_total++;
        end
      end
      if (rst_ni && pop && !empty) begin
        checked_total++;
        if (pending_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 16'(want.status), 16'(out_item_o.status));
          check_field("prescaler", want.prescaler, out_item_o.prescaler);
          check_field("reload", want.reload, out_item_o.reload);
          check_field("compare", want.compare, out_item_o.compare);
          check_field("output_enable", 16'(want.output_enable),
                      16'(out_item_o.output_enable));
          check_field("counter_run", 16'(want.counter_run), 16'(out_item_o.counter_run));
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_hz [NUM_PHASES];
    int unsigned target;
    int unsigned start;
    phase_hz = '{CLK_HZ_RESET, 32'd1, 32'hFFFF_FFFF, 32'd72_000_000, 32'd0,
                 32'd1_000_000, CLK_HZ_RESET};
    for (int c = 0; c < NUM_CH; c++) begin
      ch_prescaler[c] = '0;
      ch_reload[c] = '0;
      ch_compare[c] = '0;
      ch_duty[c] = '0;
      ch_configured[c] = 1'b0;
      ch_enabled[c] = 1'b0;
      ch_running[c] = 1'b0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_req(MODE_DUTY, 8'd0, 32'd1000, 10'd500, 1'b0);
    queue_req(MODE_ENABLE, 8'd0, 32'd1000, 10'd0, 1'b1);
    queue_req(MODE_CONFIG, 8'd0, 32'd0, 10'd500, 1'b0);
    queue_req(MODE_CONFIG, 8'd0, 32'hFFFF_FFFF, 10'd500, 1'b0);
    queue_req(MODE_CONFIG, 8'd0, 32'd200_000_000, 10'd500, 1'b0);
    queue_req(MODE_CONFIG, 8'd0, 32'd120_000_000, 10'd1023, 1'b0);
    queue_req(MODE_CONFIG, 8'd0, 32'd1, 10'd500, 1'b1);
    queue_req(MODE_ENABLE, 8'd0, 32'd0, 10'd0, 1'b1);
    queue_req(MODE_DUTY, 8'd0, 32'd0, 10'd1000, 1'b0);
    queue_req(MODE_DUTY, 8'd0, 32'd0, 10'd1001, 1'b1);
    queue_req(MODE_DUTY, 8'd0, 32'd0, 10'd0, 1'b0);
    queue_req(MODE_ENABLE, 8'd0, 32'd0, 10'd1023, 1'b0);
    queue_req(MODE_CONFIG, 8'd0, 32'd20_000, 10'd250, 1'b0);
    queue_req(MODE_UNKNOWN, 8'd0, 32'd20_000, 10'd250, 1'b1);
    queue_req(MODE_UNKNOWN, 8'd1, 32'd0, 10'd0, 1'b0);
    queue_req(MODE_CONFIG, 8'd2, 32'd20_000, 10'd250, 1'b0);
    queue_req(MODE_ENABLE, 8'd255, 32'hFFFF_FFFF, 10'd1023, 1'b1);
    queue_req(MODE_CONFIG, 8'd1, 32'd3662, 10'd1000, 1'b0);
    queue_req(MODE_CONFIG, 8'd1, 32'd3663, 10'd0, 1'b0);
    queue_req(MODE_ENABLE, 8'd1, 32'd0, 10'd0, 1'b1);
    queue_req(MODE_DUTY, 8'd1, 32'd0, 10'd1000, 1'b0);
    queue_req(MODE_DUTY, 8'd1, 32'd0, 10'd333, 1'b0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 4) begin
        phase_hz[p] = $urandom_range(2, 32'hFFFF_FFFF);
      end
      if (p > 0) begin
        write_timer_clock(phase_hz[p]);
      end
      quiet = (p == 3);
      if (p == 2) begin
        queue_req(MODE_CONFIG, 8'd0, 32'd1, 10'd1000, 1'b0);
        queue_req(MODE_CONFIG, 8'd1, 32'd2, 10'd700, 1'b0);
        queue_req(MODE_ENABLE, 8'd0, 32'd0, 10'd0, 1'b1);
      end
      target = (timer_hz == 32'd1) ? 30 : 135;
      for (int half = 0; half < 2; half++) begin
        start = queued_total;
        while (queued_total - start < target) begin
          if ($urandom_range(0, 9) < 7) begin
            add_sequence();
          end else begin
            add_noise();
          end
        end
        drain();
      end
    end

    repeat (DRAIN_WAIT) @(negedge clk_i);
    $display("Covered %0d requests over %0d timer clock settings: %0d accepted, %0d refused.",
             accepted_total, NUM_PHASES, granted_total, refused_total);
    $display("Checked %0d results with %0d field mismatches or stray results.",
             checked_total, fail_count);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("pwm_timer_setting_calculator_top verification clean");
    end else begin
      $display("pwm_timer_setting_calculator_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
